### src/two_level_bitmap_slot_allocator_top_defines.svh
// Assertion macros for the slot allocator.
`ifndef TWO_LEVEL_BITMAP_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define TWO_LEVEL_BITMAP_SLOT_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TLBSA_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TLBSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");
`else
`define TLBSA_ASSERT_IMPLIES(label, ante, cons)
`define TLBSA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/tlbsa_pkg.sv
// Types, codes and constants shared by the slot allocator files.
package tlbsa_pkg;

    localparam int PREFIX_W           = 18;
    localparam int SLOT_W             = 6;
    localparam int SLOTS              = 64;
    localparam int GRP_W              = 8;
    localparam int GRP_CNT            = SLOTS / GRP_W;
    localparam int DEFAULT_MAX_GROUPS = 16;

    typedef logic [1:0]          opcode_t;
    typedef logic [1:0]          status_t;
    typedef logic [PREFIX_W-1:0] prefix_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [SLOTS-1:0]    slot_bits_t;

    localparam slot_bits_t ALL_SLOTS_USED = '1;

    // Operation codes
    localparam opcode_t OP_REQUEST = 2'd0;
    localparam opcode_t OP_CLAIM   = 2'd1;
    localparam opcode_t OP_RELEASE = 2'd2;
    localparam opcode_t OP_NOP     = 2'd3;

    // Result status codes
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_FULL      = 2'd1;
    localparam status_t STATUS_SLOT_USED = 2'd2;
    localparam status_t STATUS_UNKNOWN   = 2'd3;

endpackage

### src/tlbsa_req_if.sv
// Request channel of the slot allocator: opcode, group prefix, slot index.
interface tlbsa_req_if
    import tlbsa_pkg::*;
();
    logic    valid;
    logic    ready;
    opcode_t opcode;
    prefix_t group_prefix;
    slot_t   slot_index;

    modport source (output valid, output opcode, output group_prefix, output slot_index,
                    input ready);
    modport sink   (input valid, input opcode, input group_prefix, input slot_index,
                    output ready);
endinterface

### src/tlbsa_rsp_if.sv
// Result channel of the slot allocator: status, prefix and slot.
interface tlbsa_rsp_if
    import tlbsa_pkg::*;
();
    logic    valid;
    logic    ready;
    status_t status;
    prefix_t out_prefix;
    slot_t   out_slot;

    modport source (output valid, output status, output out_prefix, output out_slot,
                    input ready);
    modport sink   (input valid, input status, input out_prefix, input out_slot,
                    output ready);
endinterface

### src/two_level_bitmap_slot_allocator_top.sv
// Two-level bitmap slot allocator: group table in one memory with a scan sequencer.
//
// Requests enter on req (opcode, group_prefix, slot_index) and one result per
// request leaves on rsp (status, out_prefix, out_slot), valid/ready on both.
// The group table (prefix plus 64 slot bits per entry) sits in one synchronous
// memory; groups fill entries from 0 upward, so a fill count marks the live ones.
// Every request but opcode 3 scans the F live entries, one memory read per
// cycle, then does at most one table write. A request
// that must open a new group at the smallest unused prefix adds a binary search
// over the prefixes, about log2(MAX_GROUPS + 2) passes, each a new scan of the
// live entries, and then writes the new group.
// One request is in flight at a time; req.ready is high only while idle, so a
// new request is taken only once the last one has passed its result step.
// The result sits in an output register: a stalled rsp does not stop the next
// request, which runs until its result step and waits there for the register.
// Reset clears the fill count and the handshake state; the memory contents are
// left as they are and no clearing pass runs.
`include "two_level_bitmap_slot_allocator_top_defines.svh"

module two_level_bitmap_slot_allocator_top
    import tlbsa_pkg::*;
#(
    parameter int MAX_GROUPS = DEFAULT_MAX_GROUPS
)(
    input  logic        clk,
    input  logic        rst_n,
    tlbsa_req_if.sink   req,
    tlbsa_rsp_if.source rsp
);
    localparam int IDX_W   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CNT_W   = $clog2(MAX_GROUPS + 1);
    localparam int KW      = $clog2(MAX_GROUPS + 2);
    localparam int ENTRY_W = PREFIX_W + SLOTS;
    localparam int ST_W    = 3;

    localparam logic [ST_W-1:0] S_IDLE   = 3'd0;
    localparam logic [ST_W-1:0] S_SCAN   = 3'd1;
    localparam logic [ST_W-1:0] S_DECIDE = 3'd2;
    localparam logic [ST_W-1:0] S_KMID   = 3'd3;
    localparam logic [ST_W-1:0] S_KSCAN  = 3'd4;
    localparam logic [ST_W-1:0] S_DONE   = 3'd5;

    // Control state
    logic [ST_W-1:0]  state_reg, state_next;
    logic [CNT_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             hit_reg, hit_next;
    logic             out_valid_reg, out_valid_next;

    // Payload state
    opcode_t          op_reg, op_next;
    prefix_t          key_reg, key_next;
    slot_t            slot_reg, slot_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    prefix_t          hit_key_reg, hit_key_next;
    slot_bits_t       hit_bits_reg, hit_bits_next;
    logic [KW-1:0]    lo_reg, lo_next;
    logic [KW-1:0]    hi_reg, hi_next;
    logic [KW-1:0]    mid_reg, mid_next;
    logic [KW-1:0]    less_cnt_reg, less_cnt_next;
    status_t          res_status_reg, res_status_next;
    prefix_t          res_key_reg, res_key_next;
    slot_t            res_slot_reg, res_slot_next;
    status_t          out_status_reg, out_status_next;
    prefix_t          out_prefix_reg, out_prefix_next;
    slot_t            out_slot_reg, out_slot_next;

    // Group table memory
    logic [ENTRY_W-1:0] table_mem [MAX_GROUPS];
    logic [ENTRY_W-1:0] rdata_reg;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    logic       scan_active;
    logic       scan_done;
    logic       table_full;
    logic       out_load;
    prefix_t    rd_key;
    slot_bits_t rd_bits;
    slot_t      free_slot;
    slot_bits_t free_mask;
    slot_bits_t slot_mask;
    logic [KW:0] mid_sum;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= table_mem[mem_raddr];
        end
    end

    tlbsa_free_slot u_free_slot (
        .bits (hit_bits_reg),
        .slot (free_slot)
    );

    // Scan read issue: one live entry per cycle
    assign scan_active = (state_reg == S_SCAN) || (state_reg == S_KSCAN);
    assign mem_re      = scan_active && (issue_cnt_reg < fill_cnt_reg);
    assign mem_raddr   = mem_re ? issue_cnt_reg[IDX_W-1:0] : '0;
    assign scan_done   = scan_active && !mem_re && !rd_valid_reg;

    assign rd_key     = rdata_reg[ENTRY_W-1:SLOTS];
    assign rd_bits    = rdata_reg[SLOTS-1:0];
    assign table_full = (fill_cnt_reg == CNT_W'(MAX_GROUPS));
    assign free_mask  = {{(SLOTS-1){1'b0}}, 1'b1} << free_slot;
    assign slot_mask  = {{(SLOTS-1){1'b0}}, 1'b1} << slot_reg;
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        fill_cnt_next   = fill_cnt_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_valid_next   = mem_re;
        rd_idx_next     = mem_re ? mem_raddr : rd_idx_reg;
        hit_next        = hit_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        slot_next       = slot_reg;
        hit_idx_next    = hit_idx_reg;
        hit_key_next    = hit_key_reg;
        hit_bits_next   = hit_bits_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        less_cnt_next   = less_cnt_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_prefix_next = out_prefix_reg;
        out_slot_next   = out_slot_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;

        if (mem_re)
        begin
            issue_cnt_next = issue_cnt_reg + CNT_W'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next        = req.opcode;
                    key_next       = req.group_prefix;
                    slot_next      = req.slot_index;
                    issue_cnt_next = '0;
                    hit_next       = 1'b0;
                    if (req.opcode == OP_NOP)
                    begin
                        res_status_next = STATUS_OK;
                        res_key_next    = req.group_prefix;
                        res_slot_next   = req.slot_index;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // request: lowest prefix with a free slot; claim/release: prefix match
                if (rd_valid_reg)
                begin
                    if (op_reg == OP_REQUEST)
                    begin
                        if (rd_bits != ALL_SLOTS_USED && (!hit_reg || rd_key < hit_key_reg))
                        begin
                            hit_next      = 1'b1;
                            hit_idx_next  = rd_idx_reg;
                            hit_key_next  = rd_key;
                            hit_bits_next = rd_bits;
                        end
                    end
                    else if (!hit_reg && rd_key == key_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = rd_idx_reg;
                        hit_key_next  = rd_key;
                        hit_bits_next = rd_bits;
                    end
                end
                if (scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                res_status_next = STATUS_OK;
                res_key_next    = key_reg;
                res_slot_next   = slot_reg;
                state_next      = S_DONE;
                unique case (op_reg)
                    OP_REQUEST:
                    begin
                        if (hit_reg)
                        begin
                            mem_we        = 1'b1;
                            mem_waddr     = hit_idx_reg;
                            mem_wdata     = {hit_key_reg, hit_bits_reg | free_mask};
                            res_key_next  = hit_key_reg;
                            res_slot_next = free_slot;
                        end
                        else if (table_full)
                        begin
                            res_status_next = STATUS_FULL;
                            res_key_next    = '0;
                            res_slot_next   = '0;
                        end
                        else
                        begin
                            lo_next    = '0;
                            hi_next    = KW'(MAX_GROUPS + 1);
                            state_next = S_KMID;
                        end
                    end
                    OP_CLAIM:
                    begin
                        if (hit_reg)
                        begin
                            if (hit_bits_reg[slot_reg])
                            begin
                                res_status_next = STATUS_SLOT_USED;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = hit_idx_reg;
                                mem_wdata = {hit_key_reg, hit_bits_reg | slot_mask};
                            end
                        end
                        else if (table_full)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            // open the group with only the claimed slot set
                            mem_we        = 1'b1;
                            mem_waddr     = fill_cnt_reg[IDX_W-1:0];
                            mem_wdata     = {key_reg, slot_mask};
                            fill_cnt_next = fill_cnt_reg + CNT_W'(1);
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (hit_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = hit_idx_reg;
                            mem_wdata = {hit_key_reg, hit_bits_reg & ~slot_mask};
                        end
                        else
                        begin
                            res_status_next = STATUS_UNKNOWN;
                        end
                    end
                    OP_NOP:
                    begin
                        res_status_next = STATUS_OK;
                    end
                endcase
            end

            S_KMID:
            begin
                // smallest unused prefix m: largest m with m prefixes below it
                if (hi_reg - lo_reg > KW'(1))
                begin
                    mid_next       = mid_sum[KW:1];
                    less_cnt_next  = '0;
                    issue_cnt_next = '0;
                    state_next     = S_KSCAN;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = fill_cnt_reg[IDX_W-1:0];
                    mem_wdata       = {PREFIX_W'(lo_reg), ~(ALL_SLOTS_USED >> 1)};
                    fill_cnt_next   = fill_cnt_reg + CNT_W'(1);
                    res_status_next = STATUS_OK;
                    res_key_next    = PREFIX_W'(lo_reg);
                    res_slot_next   = SLOT_W'(SLOTS - 1);
                    state_next      = S_DONE;
                end
            end

            S_KSCAN:
            begin
                if (rd_valid_reg && rd_key < PREFIX_W'(mid_reg))
                begin
                    less_cnt_next = less_cnt_reg + KW'(1);
                end
                if (scan_done)
                begin
                    if (less_cnt_reg == mid_reg)
                    begin
                        lo_next = mid_reg;
                    end
                    else
                    begin
                        hi_next = mid_reg;
                    end
                    state_next = S_KMID;
                end
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_prefix_next = res_key_reg;
                    out_slot_next   = res_slot_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_cnt_reg  <= '0;
            issue_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_cnt_reg  <= fill_cnt_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        slot_reg       <= slot_next;
        rd_idx_reg     <= rd_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_key_reg    <= hit_key_next;
        hit_bits_reg   <= hit_bits_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        less_cnt_reg   <= less_cnt_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_prefix_reg <= out_prefix_next;
        out_slot_reg   <= out_slot_next;
    end

    // Ports
    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.out_prefix = out_prefix_reg;
    assign rsp.out_slot   = out_slot_reg;

    // Checks
    `TLBSA_ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_cnt_reg <= CNT_W'(MAX_GROUPS))
    `TLBSA_ASSERT_IMPLIES(a_write_live, mem_we, CNT_W'(mem_waddr) <= fill_cnt_reg)
    `TLBSA_ASSERT_IMPLIES(a_unknown_release, out_load && res_status_reg == STATUS_UNKNOWN, op_reg == OP_RELEASE)
    `TLBSA_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready)

endmodule

### src/tlbsa_free_slot.sv
// Lowest free slot of a group bitmap; slot 63 when slots 0 to 62 are all taken.
module tlbsa_free_slot
    import tlbsa_pkg::*;
(
    input  slot_bits_t bits,
    output slot_t      slot
);
    localparam int POS_W = $clog2(GRP_W);
    localparam int SEL_W = $clog2(GRP_CNT);

    slot_bits_t       probe;
    logic [GRP_CNT-1:0] grp_zero;
    logic [POS_W-1:0] grp_pos [GRP_CNT];
    logic [SEL_W-1:0] sel;

    // Per byte: any free bit and the lowest one
    always_comb
    begin
        probe            = bits;
        probe[SLOTS-1]   = 1'b0;
        for (int g = 0; g < GRP_CNT; g++)
        begin
            grp_zero[g] = ~&probe[g*GRP_W +: GRP_W];
            grp_pos[g]  = '0;
            for (int b = GRP_W - 1; b >= 0; b--)
            begin
                if (!probe[g*GRP_W + b])
                begin
                    grp_pos[g] = POS_W'(b);
                end
            end
        end
    end

    // Lowest byte that holds a free bit
    always_comb
    begin
        sel = '0;
        for (int g = GRP_CNT - 1; g >= 0; g--)
        begin
            if (grp_zero[g])
            begin
                sel = SEL_W'(g);
            end
        end
    end

    assign slot = {sel, grp_pos[sel]};

endmodule
